// ----- sv/u8ssid_pkg.sv -----
// ---------------------------------------------------------------------------
// u8ssid_pkg
// shared types, constants and code point checks for the utf-8 string validator
// ---------------------------------------------------------------------------
package u8ssid_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PEND_W  = 2;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned POINT_W = 21;

    // sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // lead and continuation byte patterns
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'he0;
    localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hc0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hf0;
    localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'he0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hf8;
    localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hf0;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hc0;
    localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7f;

    // code point limits
    localparam logic [POINT_W-1:0] MIN_TWO       = 21'h000080;
    localparam logic [POINT_W-1:0] MIN_THREE     = 21'h000800;
    localparam logic [POINT_W-1:0] MIN_FOUR      = 21'h010000;
    localparam logic [POINT_W-1:0] MAX_POINT     = 21'h10ffff;
    localparam logic [POINT_W-1:0] SURR_LO       = 21'h00d800;
    localparam logic [POINT_W-1:0] SURR_HI       = 21'h00dfff;
    localparam logic [POINT_W-1:0] C0_MAX        = 21'h00001f;
    localparam logic [POINT_W-1:0] DEL_POINT     = 21'h00007f;
    localparam logic [POINT_W-1:0] C1_MAX        = 21'h00009f;

    // decoder state carried between bytes of one string
    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [LEN_W-1:0]   seq_len;
        logic [POINT_W-1:0] point;
        logic               error;
    } dec_state_t;

    localparam dec_state_t DEC_CLEAR = '{
        pending: '0, seq_len: '0, point: '0, error: 1'b0
    };

    // true when a completed code point must be rejected
    function automatic logic point_rejected(
        input logic [POINT_W-1:0] cp,
        input logic [LEN_W-1:0]   len
    );
        logic overlong;
        logic surrogate;
        logic control;
        overlong  = ((len == LEN_TWO)   && (cp < MIN_TWO))
                 || ((len == LEN_THREE) && (cp < MIN_THREE))
                 || ((len == LEN_FOUR)  && ((cp < MIN_FOUR) || (cp > MAX_POINT)));
        surrogate = (cp >= SURR_LO) && (cp <= SURR_HI);
        control   = (cp <= C0_MAX) || ((cp >= DEL_POINT) && (cp <= C1_MAX));
        return overlong || surrogate || control;
    endfunction

endpackage

// ----- sv/utf8_ssid_validator_unit.sv -----
// ---------------------------------------------------------------------------
// utf8_ssid_validator_unit
// byte-serial utf-8 string checker with one verdict per string
// ---------------------------------------------------------------------------
//
// channel   ports                                   role
// -------   -------------------------------------   ----------------------------
// byte      byte_valid, byte_ready, data_byte,       one string byte per
//           last_byte                                transaction, last flags end
// verdict   verdict_valid, verdict_ready,            one transaction per string,
//           string_valid                             sent after its last byte
//
// a byte waits in the input register after acceptance, then the decode
// logic loads the state and verdict registers; verdict_valid rises once the
// last byte has passed through the input register, and a new byte is
// accepted every cycle unless the input register is stalled
// the verdict register is the only point of backpressure: a held verdict
// stalls the input register only when it holds another last byte
// reset clears the input valid, the decoder state and the verdict valid
// ---------------------------------------------------------------------------
module utf8_ssid_validator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte channel
    input  logic                         byte_valid,
    output logic                         byte_ready,
    input  logic [u8ssid_pkg::BYTE_W-1:0] data_byte,
    input  logic                         last_byte,
    // verdict channel
    output logic                         verdict_valid,
    input  logic                         verdict_ready,
    output logic                         string_valid
);

    // input register
    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic [u8ssid_pkg::BYTE_W-1:0] in_byte_reg;
    logic                          in_last_reg;

    // decoder state
    u8ssid_pkg::dec_state_t        dec_reg;
    u8ssid_pkg::dec_state_t        dec_next;
    u8ssid_pkg::dec_state_t        dec_taken;

    // verdict register
    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic                          verdict_reg;
    logic                          verdict_next;

    logic                          byte_fire;
    logic                          dec_fire;
    logic                          out_fire;
    logic [u8ssid_pkg::POINT_W-1:0] point_shift;
    logic [u8ssid_pkg::PEND_W-1:0]  pend_dec;

    assign byte_fire = byte_valid && byte_ready;
    assign out_fire  = out_vld_reg && verdict_ready;

    // a non-last byte never needs the verdict register; a last byte needs it free
    assign dec_fire   = in_vld_reg && (!in_last_reg || !out_vld_reg || verdict_ready);
    assign byte_ready = !in_vld_reg || dec_fire;

    assign in_vld_next = byte_fire || (in_vld_reg && !dec_fire);

    // continuation byte appends six payload bits
    assign point_shift = {dec_reg.point[u8ssid_pkg::POINT_W-7:0], in_byte_reg[5:0]};
    assign pend_dec    = dec_reg.pending - u8ssid_pkg::PEND_W'(1);

    // decode one byte into the state
    always_comb
    begin
        dec_taken = dec_reg;
        if (!dec_reg.error)
        begin
            if (dec_reg.pending == '0)
            begin
                // lead byte
                priority if (in_byte_reg <= u8ssid_pkg::ASCII_MAX)
                begin
                    dec_taken.seq_len = u8ssid_pkg::LEN_ONE;
                    dec_taken.point   = u8ssid_pkg::POINT_W'(in_byte_reg);
                    dec_taken.error   = u8ssid_pkg::point_rejected(
                        u8ssid_pkg::POINT_W'(in_byte_reg), u8ssid_pkg::LEN_ONE);
                end
                else if ((in_byte_reg & u8ssid_pkg::MASK_LEAD2) == u8ssid_pkg::CODE_LEAD2)
                begin
                    dec_taken.seq_len = u8ssid_pkg::LEN_TWO;
                    dec_taken.pending = u8ssid_pkg::PEND_W'(1);
                    dec_taken.point   = u8ssid_pkg::POINT_W'(in_byte_reg[4:0]);
                end
                else if ((in_byte_reg & u8ssid_pkg::MASK_LEAD3) == u8ssid_pkg::CODE_LEAD3)
                begin
                    dec_taken.seq_len = u8ssid_pkg::LEN_THREE;
                    dec_taken.pending = u8ssid_pkg::PEND_W'(2);
                    dec_taken.point   = u8ssid_pkg::POINT_W'(in_byte_reg[3:0]);
                end
                else if ((in_byte_reg & u8ssid_pkg::MASK_LEAD4) == u8ssid_pkg::CODE_LEAD4)
                begin
                    dec_taken.seq_len = u8ssid_pkg::LEN_FOUR;
                    dec_taken.pending = u8ssid_pkg::PEND_W'(3);
                    dec_taken.point   = u8ssid_pkg::POINT_W'(in_byte_reg[2:0]);
                end
                else
                begin
                    // stray continuation or invalid lead
                    dec_taken.error = 1'b1;
                end
            end
            else if ((in_byte_reg & u8ssid_pkg::MASK_CONT) != u8ssid_pkg::CODE_CONT)
            begin
                // expected continuation missing
                dec_taken.error = 1'b1;
            end
            else
            begin
                dec_taken.point   = point_shift;
                dec_taken.pending = pend_dec;
                // sequence complete: range, overlong, surrogate and control checks
                if (pend_dec == '0)
                begin
                    dec_taken.error = u8ssid_pkg::point_rejected(point_shift,
                                                                  dec_reg.seq_len);
                end
            end
        end
    end

    // state update, verdict on the last byte and clear for the next string
    always_comb
    begin
        dec_next     = dec_reg;
        out_vld_next = out_vld_reg && !out_fire;
        verdict_next = verdict_reg;
        if (dec_fire)
        begin
            if (in_last_reg)
            begin
                // a cut-short sequence also fails the string
                dec_next     = u8ssid_pkg::DEC_CLEAR;
                out_vld_next = 1'b1;
                verdict_next = !(dec_taken.error || (dec_taken.pending != '0));
            end
            else
            begin
                dec_next = dec_taken;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            dec_reg     <= u8ssid_pkg::DEC_CLEAR;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            dec_reg     <= dec_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        verdict_reg <= verdict_next;
    end

    assign verdict_valid = out_vld_reg;
    assign string_valid  = verdict_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------

    // a last byte leaves the decoder clear for the next string
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire && in_last_reg |=> (dec_reg.pending == '0) && !dec_reg.error
                                    && (dec_reg.seq_len == '0))
    else $error("decoder state not cleared after last byte");

    // continuation bytes outstanding never exceed the sequence length
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_reg.pending != '0) |-> (dec_reg.seq_len > {1'b0, dec_reg.pending}))
    else $error("pending count inconsistent with sequence length");

    // a verdict appears only after a last byte went through the decoder
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(dec_fire && in_last_reg))
    else $error("verdict raised without a last byte");

    // input stage stalls only while it holds a last byte behind a held verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> in_vld_reg && in_last_reg && out_vld_reg && !verdict_ready)
    else $error("input stalled without cause");

endmodule
